FILE: src/mbsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared types, constants and the status length table for the parser.
// ----------------------------------------------------------------------------
package mbsp_pkg;

   localparam int SYSEX_CAPACITY = 1024;
   localparam int SYSEX_FILL_W   = $clog2(SYSEX_CAPACITY);

   localparam logic [7:0] REALTIME_MIN     = 8'hF8;
   localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_END = 8'hF7;
   localparam logic [7:0] STATUS_MIN       = 8'h80;

   localparam logic [1:0] KIND_MESSAGE  = 2'd0;
   localparam logic [1:0] KIND_REALTIME = 2'd1;
   localparam logic [1:0] KIND_SYSEX    = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] msg_length;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic       sysex_last;
   } mbsp_result_type;

   // Up to two results leave the parser for each byte, in order.
   typedef struct packed {
      logic [1:0]      num;
      mbsp_result_type slot0;
      mbsp_result_type slot1;
   } mbsp_push_type;

   function automatic mbsp_result_type mk_result(input logic [1:0] kind,
                                                 input logic [1:0] len,
                                                 input logic [7:0] b0,
                                                 input logic [7:0] b1,
                                                 input logic [7:0] b2,
                                                 input logic       last);
      mbsp_result_type r;
      r.kind        = kind;
      r.msg_length  = len;
      r.first_byte  = b0;
      r.second_byte = b1;
      r.third_byte  = b2;
      r.sysex_last  = last;
      return r;
   endfunction

   // Message length of a status byte; zero for a data byte and for F0, F4, F5, F7, F9, FD, FF.
   function automatic logic [1:0] length_of(input logic [7:0] status);
      logic [1:0] len;
      len = 2'd0;
      if (status < STATUS_MIN) begin
         len = 2'd0;
      end else if (status < 8'hC0) begin
         len = 2'd3;
      end else if (status < 8'hE0) begin
         len = 2'd2;
      end else if (status < STATUS_SYSEX) begin
         len = 2'd3;
      end else begin
         unique case (status[3:0])
            4'h1, 4'h3: len = 2'd2;
            4'h2: len = 2'd3;
            4'h6, 4'h8, 4'hA, 4'hB, 4'hC, 4'hE: len = 2'd1;
            default: len = 2'd0;
         endcase
      end
      return len;
   endfunction

endpackage
`default_nettype wire

FILE: src/mbsp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI parser core
// Running status, message assembly and sysex streaming for one byte a cycle while fire is high.
// ----------------------------------------------------------------------------
module mbsp_core import mbsp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fire,
   input  wire logic          sound_enabled,
   input  wire logic [7:0]    midi_byte,
   output mbsp_push_type      push
);

   logic [7:0]              rs_ff, rs_in;
   logic [1:0]              exp_ff, exp_in;
   logic [1:0]              pos_ff, pos_in;
   logic [7:0]              msg_ff [3];
   logic [7:0]              msg_in [3];
   logic [SYSEX_FILL_W-1:0] fill_ff, fill_in;

   localparam logic [SYSEX_FILL_W-1:0] FILL_LIMIT = SYSEX_FILL_W'(SYSEX_CAPACITY - 1);

   always_comb begin
      rs_in      = rs_ff;
      exp_in     = exp_ff;
      pos_in     = pos_ff;
      msg_in     = msg_ff;
      fill_in    = fill_ff;
      push.num   = 2'd0;
      push.slot0 = '0;
      push.slot1 = '0;
      if (fire && sound_enabled) begin
         if (midi_byte >= REALTIME_MIN) begin
            push.slot0 = mk_result(KIND_REALTIME, 2'd1, midi_byte, 8'h00, 8'h00, 1'b0);
            push.num   = 2'd1;
         end else if (rs_ff == STATUS_SYSEX && !midi_byte[7]) begin
            if (fill_ff < FILL_LIMIT) begin
               fill_in    = fill_ff + SYSEX_FILL_W'(1);
               push.slot0 = mk_result(KIND_SYSEX, 2'd1, midi_byte, 8'h00, 8'h00, 1'b0);
               push.num   = 2'd1;
            end
         end else begin
            if (rs_ff == STATUS_SYSEX) begin
               push.slot0 = mk_result(KIND_SYSEX, 2'd1, STATUS_SYSEX_END, 8'h00, 8'h00,
                                      1'b1);
               push.num   = 2'd1;
               fill_in    = '0;
            end
            if (midi_byte[7]) begin
               rs_in  = midi_byte;
               pos_in = 2'd0;
               exp_in = length_of(midi_byte);
               if (midi_byte == STATUS_SYSEX) begin
                  fill_in = SYSEX_FILL_W'(1);
                  if (push.num == 2'd0) begin
                     push.slot0 = mk_result(KIND_SYSEX, 2'd1, STATUS_SYSEX, 8'h00, 8'h00,
                                            1'b0);
                  end else begin
                     push.slot1 = mk_result(KIND_SYSEX, 2'd1, STATUS_SYSEX, 8'h00, 8'h00,
                                            1'b0);
                  end
                  push.num = push.num + 2'd1;
               end
            end
            if (exp_in != 2'd0) begin
               if (pos_in != 2'd3) begin
                  msg_in[pos_in] = midi_byte;
               end
               pos_in = pos_in + 2'd1;
               if (pos_in >= exp_in) begin
                  if (push.num == 2'd0) begin
                     push.slot0 = mk_result(KIND_MESSAGE, exp_in, msg_in[0],
                                            (exp_in >= 2'd2) ? msg_in[1] : 8'h00,
                                            (exp_in >= 2'd3) ? msg_in[2] : 8'h00, 1'b0);
                  end else begin
                     push.slot1 = mk_result(KIND_MESSAGE, exp_in, msg_in[0],
                                            (exp_in >= 2'd2) ? msg_in[1] : 8'h00,
                                            (exp_in >= 2'd3) ? msg_in[2] : 8'h00, 1'b0);
                  end
                  push.num = push.num + 2'd1;
                  pos_in   = 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff   <= '0;
         exp_ff  <= '0;
         pos_ff  <= '0;
         msg_ff  <= '{default: '0};
         fill_ff <= '0;
      end else begin
         rs_ff   <= rs_in;
         exp_ff  <= exp_in;
         pos_ff  <= pos_in;
         msg_ff  <= msg_in;
         fill_ff <= fill_in;
      end
   end

   // The sysex count never passes the capacity limit.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_LIMIT)
      else $error("sysex fill count beyond capacity");

   // A sysex count is only held while a sysex run is open.
   a_fill_in_sysex: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != '0) |-> (rs_ff == STATUS_SYSEX))
      else $error("sysex fill count outside a sysex run");

   // The assembly position never runs past the expected length.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= exp_ff)
      else $error("message position beyond expected length");

endmodule
`default_nettype wire

FILE: src/mbsp_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI parser result queue
// Four-entry queue that takes up to two results a cycle and gives one while rsp_ready is high.
// ----------------------------------------------------------------------------
module mbsp_outq import mbsp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire mbsp_push_type push,
   output logic               space,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output mbsp_result_type    rsp_data
);

   mbsp_result_type mem_ff [4];
   logic [1:0]      wr_ff, wr_in;
   logic [1:0]      rd_ff, rd_in;
   logic [2:0]      count_ff, count_in;
   logic            pop;

   // Room for a worst-case byte, judged before any read this cycle.
   assign space     = (count_ff <= 3'd2);
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = mem_ff[rd_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_in    = wr_ff + push.num;
      rd_in    = rd_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, push.num} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ff] <= push.slot0;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_ff + 2'd1] <= push.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.num != 2'd0) |-> (count_ff <= 3'd2))
      else $error("results pushed without room");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 3'd0) |-> (wr_ff == rd_ff))
      else $error("empty queue with pointers apart");

endmodule
`default_nettype wire

FILE: src/midi_byte_stream_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Parses raw MIDI bytes into messages with running status, realtime bytes
// and a streamed system-exclusive run.
// ----------------------------------------------------------------------------
// An accepted byte waits in the input register until the queue has room,
// is parsed, and its results are written into the result queue, which
// offers them. Throughput: one byte per cycle while each byte gives at most
// one result and rsp_ready is high; bytes that give two results can fill
// the single-read result queue and hold back the input.
// Reset is synchronous and active high: parser state and the result queue
// are cleared, and sound_enabled returns to one.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser import mbsp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_midi_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_kind,
   output logic [1:0]      rsp_msg_length,
   output logic [7:0]      rsp_first_byte,
   output logic [7:0]      rsp_second_byte,
   output logic [7:0]      rsp_third_byte,
   output logic            rsp_sysex_last
);

   // The enable register; when clear every word is taken and dropped.
   logic            sound_enabled_ff;
   // Input register: one accepted word waiting to be parsed.
   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            fire;
   logic            space;
   mbsp_push_type   push;
   mbsp_result_type rsp_data;

   // A held word is parsed as soon as the queue has room for two results,
   // and the input register refills in that same cycle.
   assign fire      = in_valid_ff && space;
   assign req_ready = !in_valid_ff || space;

   always_ff @(posedge clock) begin
      if (reset) begin
         sound_enabled_ff <= 1'b1;
         in_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            sound_enabled_ff <= csr_wr_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_midi_byte;
      end
   end

   mbsp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .sound_enabled (sound_enabled_ff),
      .midi_byte     (in_byte_ff),
      .push          (push)
   );

   mbsp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_msg_length  = rsp_data.msg_length;
   assign rsp_first_byte  = rsp_data.first_byte;
   assign rsp_second_byte = rsp_data.second_byte;
   assign rsp_third_byte  = rsp_data.third_byte;
   assign rsp_sysex_last  = rsp_data.sysex_last;

endmodule
`default_nettype wire
